>>> rtl/kmt_pkg.sv
// Package for the keyed mutex table: sizes, request and status codes,
// transfer structs, table entry layout and controller state encoding.
// No dependencies.
package kmt_pkg;

  // Sizes. MAX_PROCS must be a power of two: queue pointers wrap by truncation.
  localparam int NUM_LOCKS = 16;
  localparam int MAX_PROCS = 64;
  localparam int LK_W      = $clog2(NUM_LOCKS);
  localparam int PID_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = PID_W + 1;
  localparam int KEY_W     = 31;
  localparam int FIFO_AW   = LK_W + PID_W;
  localparam int FIFO_DEPTH = NUM_LOCKS * MAX_PROCS;

  typedef enum logic [1:0] {
    REQ_INIT = 2'd0,
    REQ_ACQ  = 2'd1,
    REQ_REL  = 2'd2,
    REQ_EXIT = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BLOCKED = 2'd1,
    ST_NOFREE  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
    logic [3:0]       lock_index;
    logic [5:0]       pid;
  } in_item_t;

  typedef struct packed {
    logic [3:0] result_lock;
    logic [1:0] status;
    logic       handoff_valid;
    logic [5:0] new_owner;
    logic       last;
  } out_item_t;

  // One lock table entry
  typedef struct packed {
    logic             kv;
    logic [KEY_W-1:0] key;
    logic             held;
    logic [PID_W-1:0] owner;
    logic [PID_W-1:0] head;
    logic [CNT_W-1:0] cnt;
  } lk_ent_t;

  localparam int ENT_W = $bits(lk_ent_t);

  typedef struct packed {
    logic            re;
    logic [LK_W-1:0] raddr;
    logic            we;
    logic [LK_W-1:0] waddr;
    lk_ent_t         wdata;
  } tbl_req_t;

  typedef struct packed {
    logic               re;
    logic [FIFO_AW-1:0] raddr;
    logic               we;
    logic [FIFO_AW-1:0] waddr;
    logic [PID_W-1:0]   wdata;
  } fifo_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_POP,
    S_CHK,
    S_NEXT
  } state_t;

endpackage

>>> rtl/kmt_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module kmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/kmt_ctrl.sv
// Request sequencer: reads, modifies and writes back lock table entries and
// wait queues, keeps exited marks and table valid bits. Uses kmt_pkg.
module kmt_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  kmt_pkg::in_item_t        in_item,
  output logic                     busy,
  output kmt_pkg::tbl_req_t        tbl_req,
  input  kmt_pkg::lk_ent_t         tbl_rdata,
  output kmt_pkg::fifo_req_t       fifo_req,
  input  logic [kmt_pkg::PID_W-1:0] fifo_rdata,
  output logic                     res_valid,
  output kmt_pkg::out_item_t       res_item
);
  import kmt_pkg::*;

  state_t              state_r, state_nxt;
  req_t                op_r, op_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [PID_W-1:0]    pid_r, pid_nxt;
  logic [LK_W-1:0]     idx_r, idx_nxt;
  lk_ent_t             ent_r, ent_nxt;
  logic                free_v_r, free_v_nxt;
  logic [LK_W-1:0]     free_idx_r, free_idx_nxt;
  lk_ent_t             free_ent_r, free_ent_nxt;
  logic                pend_v_r, pend_v_nxt;
  out_item_t           pend_r, pend_nxt;
  logic [NUM_LOCKS-1:0] tbl_vld_r, tbl_vld_nxt;
  logic [MAX_PROCS-1:0] exited_r, exited_nxt;

  lk_ent_t ent;
  logic    key_hit, own_hit, last_idx, p_exited;

  // entry never written reads as its reset value
  assign ent      = tbl_vld_r[idx_r] ? tbl_rdata : '0;
  assign key_hit  = ent.kv && (ent.key == key_r);
  assign own_hit  = ent.held && (ent.owner == pid_r);
  assign last_idx = (idx_r == LK_W'(NUM_LOCKS - 1));
  assign p_exited = exited_r[fifo_rdata];
  assign busy     = (state_r != S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_RD;
      end
      S_RD: state_nxt = S_EVAL;
      S_EVAL: begin
        case (op_r)
          REQ_INIT: state_nxt = (key_hit || last_idx) ? S_IDLE : S_RD;
          REQ_ACQ:  state_nxt = S_IDLE;
          REQ_REL:  state_nxt = S_POP;
          REQ_EXIT: state_nxt = own_hit ? S_POP : (last_idx ? S_IDLE : S_RD);
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_POP: begin
        if (ent_r.cnt != '0) state_nxt = S_CHK;
        else state_nxt = (op_r == REQ_REL) ? S_IDLE : S_NEXT;
      end
      S_CHK: begin
        if (p_exited) state_nxt = S_POP;
        else state_nxt = (op_r == REQ_REL) ? S_IDLE : S_NEXT;
      end
      S_NEXT: state_nxt = last_idx ? S_IDLE : S_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory requests and results
  always_comb begin
    lk_ent_t          w_ent;
    logic [LK_W-1:0]  w_idx;
    logic             fin;
    logic             fin_hv;
    logic [PID_W-1:0] fin_who;
    lk_ent_t          fin_ent;
    out_item_t        r;

    op_nxt       = op_r;
    key_nxt      = key_r;
    pid_nxt      = pid_r;
    idx_nxt      = idx_r;
    ent_nxt      = ent_r;
    free_v_nxt   = free_v_r;
    free_idx_nxt = free_idx_r;
    free_ent_nxt = free_ent_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    tbl_vld_nxt  = tbl_vld_r;
    exited_nxt   = exited_r;
    tbl_req      = '0;
    fifo_req     = '0;
    res_valid    = 1'b0;
    res_item     = '0;
    w_ent        = ent;
    w_idx        = idx_r;
    fin          = 1'b0;
    fin_hv       = 1'b0;
    fin_who      = '0;
    fin_ent      = ent_r;
    r            = '0;

    tbl_req.raddr = idx_r;
    tbl_req.re    = (state_r == S_RD);

    case (state_r)
      // latch the request
      S_IDLE: begin
        if (start) begin
          op_nxt     = req_t'(in_item.req_type);
          key_nxt    = in_item.key;
          pid_nxt    = in_item.pid;
          idx_nxt    = (req_t'(in_item.req_type) == REQ_ACQ ||
                        req_t'(in_item.req_type) == REQ_REL) ? in_item.lock_index : '0;
          free_v_nxt = 1'b0;
          pend_v_nxt = 1'b0;
          if (req_t'(in_item.req_type) == REQ_EXIT) exited_nxt[in_item.pid] = 1'b1;
        end
      end

      S_EVAL: begin
        case (op_r)
          // key search, remembering the first free entry
          REQ_INIT: begin
            if (key_hit) begin
              res_valid = 1'b1;
              res_item.result_lock = idx_r;
              res_item.status = ST_OK;
              res_item.last = 1'b1;
            end else begin
              if (!ent.kv && !free_v_r) begin
                free_v_nxt   = 1'b1;
                free_idx_nxt = idx_r;
                free_ent_nxt = ent;
              end
              if (last_idx) begin
                res_valid = 1'b1;
                res_item.last = 1'b1;
                if (free_v_r || !ent.kv) begin
                  w_ent = free_v_r ? free_ent_r : ent;
                  w_idx = free_v_r ? free_idx_r : idx_r;
                  w_ent.kv  = 1'b1;
                  w_ent.key = key_r;
                  tbl_req.we    = 1'b1;
                  tbl_req.waddr = w_idx;
                  tbl_req.wdata = w_ent;
                  res_item.result_lock = w_idx;
                  res_item.status = ST_OK;
                end else begin
                  res_item.status = ST_NOFREE;
                end
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
          end
          // grant, enqueue or refuse
          REQ_ACQ: begin
            exited_nxt[pid_r] = 1'b0;
            res_valid = 1'b1;
            res_item.result_lock = idx_r;
            res_item.last = 1'b1;
            if (!ent.held) begin
              w_ent.held  = 1'b1;
              w_ent.owner = pid_r;
              tbl_req.we    = 1'b1;
              tbl_req.waddr = idx_r;
              tbl_req.wdata = w_ent;
              res_item.status = ST_OK;
            end else if (ent.cnt != CNT_W'(MAX_PROCS)) begin
              fifo_req.we    = 1'b1;
              fifo_req.waddr = {idx_r, ent.head + ent.cnt[PID_W-1:0]};
              fifo_req.wdata = pid_r;
              w_ent.cnt      = ent.cnt + 1'b1;
              tbl_req.we    = 1'b1;
              tbl_req.waddr = idx_r;
              tbl_req.wdata = w_ent;
              res_item.status = ST_BLOCKED;
            end else begin
              res_item.status = ST_FULL;
            end
          end
          REQ_REL: ent_nxt = ent;
          // scan for locks owned by the exiting process
          REQ_EXIT: begin
            if (own_hit) begin
              ent_nxt = ent;
            end else if (last_idx) begin
              if (pend_v_r) begin
                res_valid = 1'b1;
                res_item = pend_r;
                res_item.last = 1'b1;
                pend_v_nxt = 1'b0;
              end
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          default: ;
        endcase
      end

      // pop the oldest waiter or free the lock
      S_POP: begin
        if (ent_r.cnt != '0) begin
          fifo_req.re    = 1'b1;
          fifo_req.raddr = {idx_r, ent_r.head};
          ent_nxt.head   = ent_r.head + 1'b1;
          ent_nxt.cnt    = ent_r.cnt - 1'b1;
        end else begin
          fin = 1'b1;
          fin_ent.held  = 1'b0;
          fin_ent.owner = '0;
        end
      end

      // skip exited waiters, hand off otherwise
      S_CHK: begin
        if (!p_exited) begin
          fin = 1'b1;
          fin_hv = 1'b1;
          fin_who = fifo_rdata;
          fin_ent.held  = 1'b1;
          fin_ent.owner = fifo_rdata;
        end
      end

      S_NEXT: begin
        if (last_idx) begin
          if (pend_v_r) begin
            res_valid = 1'b1;
            res_item = pend_r;
            res_item.last = 1'b1;
            pend_v_nxt = 1'b0;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      default: ;
    endcase

    // release done: write back; exit results lag one behind to mark the last
    if (fin) begin
      tbl_req.we    = 1'b1;
      tbl_req.waddr = idx_r;
      tbl_req.wdata = fin_ent;
      r.result_lock   = idx_r;
      r.status        = ST_OK;
      r.handoff_valid = fin_hv;
      r.new_owner     = fin_who;
      if (op_r == REQ_REL) begin
        res_valid = 1'b1;
        res_item  = r;
        res_item.last = 1'b1;
      end else begin
        if (pend_v_r) begin
          res_valid = 1'b1;
          res_item  = pend_r;
        end
        pend_nxt   = r;
        pend_v_nxt = 1'b1;
      end
    end

    if (tbl_req.we) tbl_vld_nxt[tbl_req.waddr] = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      free_v_r  <= 1'b0;
      pend_v_r  <= 1'b0;
      tbl_vld_r <= '0;
      exited_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      free_v_r  <= free_v_nxt;
      pend_v_r  <= pend_v_nxt;
      tbl_vld_r <= tbl_vld_nxt;
      exited_r  <= exited_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    pid_r      <= pid_nxt;
    idx_r      <= idx_nxt;
    ent_r      <= ent_nxt;
    free_idx_r <= free_idx_nxt;
    free_ent_r <= free_ent_nxt;
    pend_r     <= pend_nxt;
  end

endmodule

>>> rtl/keyed_mutex_table_with_wait_queues.sv
// Keyed mutex table with per-lock FIFO wait queues.
// Acquire reads the entry and grants, enqueues or refuses; init scans entries until
// the key or the last one; release pops waiters, skipping exited ones, until one
// takes over or the lock is freed; exit scans every entry and releases each one it owns.
// Throughput: one request at a time, the next accepted as the final result shows.
// Reset is synchronous, active low; no clearing pass, valid bits mark written entries.
module keyed_mutex_table_with_wait_queues (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  kmt_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output kmt_pkg::out_item_t out_item
);
  import kmt_pkg::*;

  tbl_req_t         tbl_req;
  lk_ent_t          tbl_rdata;
  logic [ENT_W-1:0] tbl_rword;
  fifo_req_t        fifo_req;
  logic [PID_W-1:0] fifo_rdata;
  logic             res_valid;
  out_item_t        res_item;
  logic             out_valid_r;
  out_item_t        out_item_r;

  kmt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .tbl_req    (tbl_req),
    .tbl_rdata  (tbl_rdata),
    .fifo_req   (fifo_req),
    .fifo_rdata (fifo_rdata),
    .res_valid  (res_valid),
    .res_item   (res_item)
  );

  // lock table
  kmt_ram #(.WIDTH(ENT_W), .DEPTH(NUM_LOCKS)) u_tbl (
    .clk   (clk),
    .we    (tbl_req.we),
    .waddr (tbl_req.waddr),
    .wdata (tbl_req.wdata),
    .re    (tbl_req.re),
    .raddr (tbl_req.raddr),
    .rdata (tbl_rword)
  );
  assign tbl_rdata = lk_ent_t'(tbl_rword);

  // wait queues, MAX_PROCS slots per lock
  kmt_ram #(.WIDTH(PID_W), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .we    (fifo_req.we),
    .waddr (fifo_req.waddr),
    .wdata (fifo_req.wdata),
    .re    (fifo_req.re),
    .raddr (fifo_req.raddr),
    .rdata (fifo_rdata)
  );

  // result register, one cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= res_item;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> rtl/kmt_chk.sv
// Port-level checker for the keyed mutex table, bound to the top level.
// Uses kmt_pkg.
module kmt_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input kmt_pkg::in_item_t  in_item,
  input logic               busy,
  input logic               out_valid,
  input kmt_pkg::out_item_t out_item
);
  import kmt_pkg::*;

  // an accepted request always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // results only follow work in progress
  a_res_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  // final result of a request leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> !busy)
    else $error("block still busy after final result");

  // a non-final result means more results are coming
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("non-final result while idle");

  // a handoff never comes with a failure status
  a_handoff_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.handoff_valid |-> out_item.status == ST_OK)
    else $error("handoff with failure status");

endmodule

bind keyed_mutex_table_with_wait_queues kmt_chk u_kmt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .in_item   (in_item),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
